// File: rtl/gce_pkg.sv
// Package: shared types, register indexes and constants of the glyph color expansion block.
`default_nettype none
package gce_pkg;

  // Default sizes handed to the top level parameters
  localparam int ADDR_BITS_DEFAULT = 24;
  localparam int MAX_GLYPH_DEFAULT = 32;

  // Fixed widths of the interface fields
  localparam int OUT_ADDR_BITS  = 24;
  localparam int CFG_INDEX_BITS = 4;
  localparam int CFG_DATA_BITS  = 24;
  // Width of a clamped glyph dimension (holds up to 127)
  localparam int DIM_BITS       = 7;
  // Bytes-per-row values (up to 8)
  localparam int BPR_BITS       = 4;
  // Entries in the front-to-back command queue
  localparam int QUEUE_DEPTH    = 2;

  // Register indexes on the configuration port
  localparam logic [CFG_INDEX_BITS-1:0] CFG_FG_COLOR     = 4'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_BACK_COLOR   = 4'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_GLYPH_WIDTH  = 4'd2;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_GLYPH_HEIGHT = 4'd3;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_LINE_STRIDE  = 4'd4;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_START_X      = 4'd5;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_START_Y      = 4'd6;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_FRAME_BASE   = 4'd7;

  // Register reset values
  localparam logic [7:0]  FG_COLOR_RESET     = 8'd255;
  localparam logic [7:0]  BACK_COLOR_RESET   = 8'd0;
  localparam logic [5:0]  GLYPH_WIDTH_RESET  = 6'd8;
  localparam logic [5:0]  GLYPH_HEIGHT_RESET = 6'd8;
  localparam logic [12:0] LINE_STRIDE_RESET  = 13'd320;

  // Configuration register file
  typedef struct packed {
    logic [7:0]  fg_color;
    logic [7:0]  back_color;
    logic [5:0]  glyph_width;
    logic [5:0]  glyph_height;
    logic [12:0] line_stride;
    logic [11:0] start_x;
    logic [11:0] start_y;
    logic [23:0] frame_base;
  } cfg_t;

  // Input item: one glyph row byte
  typedef struct packed {
    logic [7:0] font_byte;
    logic       first_of_string;
  } glyph_t;

  // Result item: one frame-buffer write
  typedef struct packed {
    logic [OUT_ADDR_BITS-1:0] pixel_address;
    logic [7:0]               pixel_color;
    logic                     last;
  } pixel_t;

  // Command passed from front to back (address travels alongside)
  typedef struct packed {
    logic [7:0] font_byte;
    logic [2:0] count_m1;
  } cmd_t;

endpackage
`default_nettype wire

// File: rtl/gce_front.sv
// Front end: accepts glyph bytes, tracks row/character position, issues expand commands.
`default_nettype none
module gce_front
  import gce_pkg::*;
#(
  parameter int ADDR_BITS = ADDR_BITS_DEFAULT,
  parameter int MAX_GLYPH = MAX_GLYPH_DEFAULT
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire cfg_t                 cfg,
  input  wire logic                 glyph_valid,
  output logic                      glyph_ready,
  input  wire glyph_t               glyph,
  input  wire logic                 q_ready,
  output logic                      push,
  output cmd_t                      cmd,
  output logic [ADDR_BITS-1:0]      cmd_addr
);

  localparam int BPR_MAX = (MAX_GLYPH + 7) / 8;
  localparam int BIR_W   = (BPR_MAX > 1) ? $clog2(BPR_MAX) : 1;
  localparam int RC_W    = $clog2(MAX_GLYPH);
  localparam logic [DIM_BITS-1:0] MAX_DIM = DIM_BITS'(MAX_GLYPH);

  // Position state
  logic [RC_W-1:0]      row_count, row_count_next;
  logic [BIR_W-1:0]     byte_in_row, byte_in_row_next;
  logic [ADDR_BITS-1:0] char_origin_addr, char_origin_addr_next;
  logic [ADDR_BITS-1:0] row_start_addr, row_start_addr_next;

  logic [DIM_BITS-1:0]  gw, gh, width, height;
  logic [BPR_BITS-1:0]  bytes_per_row;
  logic [24:0]          origin_prod;
  logic [31:0]          origin_sum;
  logic [ADDR_BITS-1:0] origin;
  logic [ADDR_BITS-1:0] rs0, co0, co_adv;
  logic [BIR_W-1:0]     bir0, bir1;
  logic [RC_W-1:0]      rc0, rc1;
  logic [DIM_BITS-1:0]  done, remain;
  logic [BPR_BITS-1:0]  bir_inc;
  logic [DIM_BITS-1:0]  rc_inc;
  logic                 row_end, glyph_end;

  assign glyph_ready = q_ready;
  assign push        = glyph_valid && q_ready;

  // Clamp glyph dimensions to 1..MAX_GLYPH
  always_comb begin
    gw = DIM_BITS'(cfg.glyph_width);
    gh = DIM_BITS'(cfg.glyph_height);
    if (gw == '0) begin
      width = DIM_BITS'(1);
    end else if (gw > MAX_DIM) begin
      width = MAX_DIM;
    end else begin
      width = gw;
    end
    if (gh == '0) begin
      height = DIM_BITS'(1);
    end else if (gh > MAX_DIM) begin
      height = MAX_DIM;
    end else begin
      height = gh;
    end
    bytes_per_row = BPR_BITS'((8'(width) + 8'd7) >> 3);
  end

  // String origin: frame_base + start_y * line_stride + start_x
  assign origin_prod = 25'(cfg.start_y) * 25'(cfg.line_stride);
  assign origin_sum  = 32'(cfg.frame_base) + 32'(origin_prod) + 32'(cfg.start_x);
  assign origin      = origin_sum[ADDR_BITS-1:0];

  // Restart, wrap, command and position update
  always_comb begin
    rs0  = glyph.first_of_string ? origin : row_start_addr;
    co0  = glyph.first_of_string ? origin : char_origin_addr;
    bir0 = glyph.first_of_string ? '0 : byte_in_row;
    rc0  = glyph.first_of_string ? '0 : row_count;

    // counters left out of range by a new glyph size start over
    bir1 = (BPR_BITS'(bir0) >= bytes_per_row) ? '0 : bir0;
    rc1  = (DIM_BITS'(rc0) >= height) ? '0 : rc0;

    done   = DIM_BITS'({bir1, 3'b000});
    remain = width - done;
    cmd.font_byte = glyph.font_byte;
    cmd.count_m1  = (remain > DIM_BITS'(8)) ? 3'd7 : 3'(remain - DIM_BITS'(1));
    cmd_addr      = ADDR_BITS'(rs0 + ADDR_BITS'(done));

    bir_inc   = BPR_BITS'(bir1) + BPR_BITS'(1);
    rc_inc    = DIM_BITS'(rc1) + DIM_BITS'(1);
    row_end   = bir_inc >= bytes_per_row;
    glyph_end = row_end && (rc_inc >= height);
    co_adv    = ADDR_BITS'(co0 + ADDR_BITS'(width));

    byte_in_row_next      = row_end ? '0 : bir_inc[BIR_W-1:0];
    row_count_next        = rc1;
    char_origin_addr_next = co0;
    row_start_addr_next   = rs0;
    if (glyph_end) begin
      row_count_next        = '0;
      char_origin_addr_next = co_adv;
      row_start_addr_next   = co_adv;
    end else if (row_end) begin
      row_count_next      = rc_inc[RC_W-1:0];
      row_start_addr_next = ADDR_BITS'(rs0 + ADDR_BITS'(cfg.line_stride));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count        <= '0;
      byte_in_row      <= '0;
      char_origin_addr <= '0;
      row_start_addr   <= '0;
    end else if (push) begin
      row_count        <= row_count_next;
      byte_in_row      <= byte_in_row_next;
      char_origin_addr <= char_origin_addr_next;
      row_start_addr   <= row_start_addr_next;
    end
  end

  // A stored row count lies inside the current glyph height unless the configuration changed
  a_row_in_range: assert property (@(posedge clk) disable iff (rst)
    push |=> (DIM_BITS'(row_count) < height) || $changed(cfg))
    else $error("row count left glyph height");

endmodule
`default_nettype wire

// File: rtl/gce_queue.sv
// Short command queue between front and back.
`default_nettype none
module gce_queue
  import gce_pkg::*;
#(
  parameter int ADDR_BITS = ADDR_BITS_DEFAULT
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 push,
  input  wire cmd_t                 push_cmd,
  input  wire logic [ADDR_BITS-1:0] push_addr,
  output logic                      ready,
  input  wire logic                 pop,
  output logic                      valid,
  output cmd_t                      pop_cmd,
  output logic [ADDR_BITS-1:0]      pop_addr
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t                 cmd_store  [QUEUE_DEPTH];
  logic [ADDR_BITS-1:0] addr_store [QUEUE_DEPTH];
  logic [PTR_W-1:0]     wr_ptr, rd_ptr;
  logic [CNT_W-1:0]     fill;

  assign ready    = fill != CNT_W'(QUEUE_DEPTH);
  assign valid    = fill != '0;
  assign pop_cmd  = cmd_store[rd_ptr];
  assign pop_addr = addr_store[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      cmd_store[wr_ptr]  <= push_cmd;
      addr_store[wr_ptr] <= push_addr;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : PTR_W'(wr_ptr + PTR_W'(1));
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : PTR_W'(rd_ptr + PTR_W'(1));
      end
      if (push && !pop) begin
        fill <= CNT_W'(fill + CNT_W'(1));
      end else if (pop && !push) begin
        fill <= CNT_W'(fill - CNT_W'(1));
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> ready)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> valid)
    else $error("pop from empty queue");

endmodule
`default_nettype wire

// File: rtl/gce_back.sv
// Back end: expands commands into registered pixel writes, one per cycle unless stalled.
`default_nettype none
module gce_back
  import gce_pkg::*;
#(
  parameter int ADDR_BITS = ADDR_BITS_DEFAULT
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire cfg_t                 cfg,
  input  wire logic                 q_valid,
  input  wire cmd_t                 q_cmd,
  input  wire logic [ADDR_BITS-1:0] q_addr,
  output logic                      pop,
  output logic                      pixel_valid,
  input  wire logic                 pixel_ready,
  output pixel_t                    pixel
);

  // Command being expanded
  logic                 cmd_valid;
  logic [7:0]           font_byte;
  logic [2:0]           count_m1;
  logic [2:0]           idx;
  logic [ADDR_BITS-1:0] addr;

  logic                 emit, is_last, bit_set;
  logic [31:0]          addr_ext;

  assign emit     = cmd_valid && (!pixel_valid || pixel_ready);
  assign is_last  = idx == count_m1;
  assign pop      = q_valid && (!cmd_valid || (emit && is_last));
  assign bit_set  = font_byte[3'd7 - idx];
  assign addr_ext = 32'(addr);

  // Command register and pixel walk
  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (pop) begin
      cmd_valid <= 1'b1;
    end else if (emit && is_last) begin
      cmd_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      font_byte <= q_cmd.font_byte;
      count_m1  <= q_cmd.count_m1;
      idx       <= '0;
      addr      <= q_addr;
    end else if (emit) begin
      idx  <= idx + 3'd1;
      addr <= ADDR_BITS'(addr + ADDR_BITS'(1));
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_valid <= 1'b0;
    end else if (emit) begin
      pixel_valid <= 1'b1;
    end else if (pixel_ready) begin
      pixel_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      pixel.pixel_address <= addr_ext[OUT_ADDR_BITS-1:0];
      pixel.pixel_color   <= bit_set ? cfg.fg_color : cfg.back_color;
      pixel.last          <= is_last;
    end
  end

  a_idx_in_range: assert property (@(posedge clk) disable iff (rst)
    cmd_valid |-> idx <= count_m1)
    else $error("pixel index past command count");

  a_drain_when_empty: assert property (@(posedge clk) disable iff (rst)
    (emit && is_last && !q_valid) |=> !cmd_valid)
    else $error("command kept after its last pixel");

endmodule
`default_nettype wire

// File: rtl/glyph_color_expansion.sv
// Top level: configuration registers and the front / queue / back glyph expansion pipeline.
// Each accepted font byte becomes min(8, width - 8 * byte index) pixel writes of
// 8-bit color, issued one per cycle on the pixel channel while the receiver is ready.
// The single pixel output register sets that rate. The front accepts a byte in any
// cycle in which the two-entry command queue has room, so bytes are taken while
// earlier ones are still being expanded; when the back end is idle, the first pixel
// of a byte passes the queue, the command register and the output register in turn.
// Configuration writes are always ready and take effect on the next cycle; write
// them only while idle.
`default_nettype none
module glyph_color_expansion
  import gce_pkg::*;
#(
  parameter int ADDR_BITS = ADDR_BITS_DEFAULT,
  parameter int MAX_GLYPH = MAX_GLYPH_DEFAULT
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0]  cfg_data,
  input  wire logic                      glyph_valid,
  output logic                           glyph_ready,
  input  wire glyph_t                    glyph,
  output logic                           pixel_valid,
  input  wire logic                      pixel_ready,
  output pixel_t                         pixel
);

  cfg_t                 cfg;
  logic                 push, q_ready, q_valid, pop;
  cmd_t                 push_cmd, q_cmd;
  logic [ADDR_BITS-1:0] push_addr, q_addr;

  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.fg_color     <= FG_COLOR_RESET;
      cfg.back_color   <= BACK_COLOR_RESET;
      cfg.glyph_width  <= GLYPH_WIDTH_RESET;
      cfg.glyph_height <= GLYPH_HEIGHT_RESET;
      cfg.line_stride  <= LINE_STRIDE_RESET;
      cfg.start_x      <= '0;
      cfg.start_y      <= '0;
      cfg.frame_base   <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_FG_COLOR:     cfg.fg_color     <= cfg_data[7:0];
        CFG_BACK_COLOR:   cfg.back_color   <= cfg_data[7:0];
        CFG_GLYPH_WIDTH:  cfg.glyph_width  <= cfg_data[5:0];
        CFG_GLYPH_HEIGHT: cfg.glyph_height <= cfg_data[5:0];
        CFG_LINE_STRIDE:  cfg.line_stride  <= cfg_data[12:0];
        CFG_START_X:      cfg.start_x      <= cfg_data[11:0];
        CFG_START_Y:      cfg.start_y      <= cfg_data[11:0];
        CFG_FRAME_BASE:   cfg.frame_base   <= cfg_data[23:0];
        default: ;
      endcase
    end
  end

  gce_front #(
    .ADDR_BITS (ADDR_BITS),
    .MAX_GLYPH (MAX_GLYPH)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .glyph_valid (glyph_valid),
    .glyph_ready (glyph_ready),
    .glyph       (glyph),
    .q_ready     (q_ready),
    .push        (push),
    .cmd         (push_cmd),
    .cmd_addr    (push_addr)
  );

  gce_queue #(
    .ADDR_BITS (ADDR_BITS)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_cmd  (push_cmd),
    .push_addr (push_addr),
    .ready     (q_ready),
    .pop       (pop),
    .valid     (q_valid),
    .pop_cmd   (q_cmd),
    .pop_addr  (q_addr)
  );

  gce_back #(
    .ADDR_BITS (ADDR_BITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .q_valid     (q_valid),
    .q_cmd       (q_cmd),
    .q_addr      (q_addr),
    .pop         (pop),
    .pixel_valid (pixel_valid),
    .pixel_ready (pixel_ready),
    .pixel       (pixel)
  );

endmodule
`default_nettype wire

// File: tb/sv/glyph_color_expansion_tb.sv
// Testbench for glyph_color_expansion: directed and random glyph strings checked per pixel.
`timescale 1ns / 1ps
module glyph_color_expansion_tb;
  import gce_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;
  logic glyph_valid = 1'b0;
  logic glyph_ready;
  glyph_t glyph_in = '0;
  logic pixel_valid;
  logic pixel_ready = 1'b0;
  pixel_t pixel_out;

  // Predictor copy of the registers and the drawing position
  cfg_t regs;
  int unsigned row_idx;
  int unsigned byte_idx;
  logic [OUT_ADDR_BITS-1:0] char_base;
  logic [OUT_ADDR_BITS-1:0] row_base;

  pixel_t pending_pixels[$];
  pixel_t want_pixel;
  int unsigned mismatch_count = 0;
  int unsigned stall_left = 0;
  bit quiet = 1'b0;

  glyph_color_expansion dut (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .glyph_valid(glyph_valid),
    .glyph_ready(glyph_ready),
    .glyph(glyph_in),
    .pixel_valid(pixel_valid),
    .pixel_ready(pixel_ready),
    .pixel(pixel_out)
  );

  always #10 clk = ~clk;

  // Gap length: mostly none, some short, a few long
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 30);
  endfunction

  // Value biased toward the ends of its range
  function automatic logic [23:0] pick_edge(input int unsigned lo, input int unsigned hi);
    int unsigned r;
    r = $urandom_range(0, 5);
    if (r == 0) return 24'(lo);
    if (r == 1) return 24'(hi);
    return 24'($urandom_range(lo, hi));
  endfunction

  // Glyph dimensions are held to 1..MAX_GLYPH
  function automatic int unsigned clamp_dim(input logic [5:0] v);
    if (v == 6'd0) return 1;
    if (int'(v) > MAX_GLYPH_DEFAULT) return MAX_GLYPH_DEFAULT;
    return int'(v);
  endfunction

  task automatic reset_model();
    regs = '0;
    regs.fg_color = FG_COLOR_RESET;
    regs.back_color = BACK_COLOR_RESET;
    regs.glyph_width = GLYPH_WIDTH_RESET;
    regs.glyph_height = GLYPH_HEIGHT_RESET;
    regs.line_stride = LINE_STRIDE_RESET;
    row_idx = 0;
    byte_idx = 0;
    char_base = '0;
    row_base = '0;
  endtask

  // Expand one accepted font byte into its expected pixel writes
  task automatic expand_glyph(input glyph_t g);
    int unsigned w, h, bpr, done, cnt, i;
    logic [63:0] org;
    pixel_t p;
    w = clamp_dim(regs.glyph_width);
    h = clamp_dim(regs.glyph_height);
    bpr = (w + 7) / 8;
    if (g.first_of_string) begin
      org = 64'(regs.frame_base) + 64'(regs.start_y) * 64'(regs.line_stride)
            + 64'(regs.start_x);
      char_base = org[OUT_ADDR_BITS-1:0];
      row_base = org[OUT_ADDR_BITS-1:0];
      row_idx = 0;
      byte_idx = 0;
    end
    // counters left out of range by a register change start over
    if (byte_idx >= bpr) byte_idx = 0;
    if (row_idx >= h) row_idx = 0;
    done = byte_idx * 8;
    cnt = (w - done > 8) ? 8 : w - done;
    for (i = 0; i < cnt; i++) begin
      p.pixel_address = row_base + OUT_ADDR_BITS'(done + i);
      p.pixel_color = g.font_byte[7 - i] ? regs.fg_color : regs.back_color;
      p.last = (i + 1 == cnt);
      pending_pixels.push_back(p);
    end
    // advance byte, row and character position
    byte_idx++;
    if (byte_idx >= bpr) begin
      byte_idx = 0;
      row_idx++;
      row_base = row_base + OUT_ADDR_BITS'(regs.line_stride);
      if (row_idx >= h) begin
        row_idx = 0;
        char_base = char_base + OUT_ADDR_BITS'(w);
        row_base = char_base;
      end
    end
  endtask

  // Register write; only called while the block is idle
  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx, input logic [23:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_FG_COLOR:     regs.fg_color = val[7:0];
      CFG_BACK_COLOR:   regs.back_color = val[7:0];
      CFG_GLYPH_WIDTH:  regs.glyph_width = val[5:0];
      CFG_GLYPH_HEIGHT: regs.glyph_height = val[5:0];
      CFG_LINE_STRIDE:  regs.line_stride = val[12:0];
      CFG_START_X:      regs.start_x = val[11:0];
      CFG_START_Y:      regs.start_y = val[11:0];
      CFG_FRAME_BASE:   regs.frame_base = val[23:0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Send one font byte; valid stays up for a back-to-back item
  task automatic send_glyph(input logic [7:0] b, input logic f);
    int unsigned gap;
    glyph_t item;
    gap = pick_gap();
    if (gap > 0) begin
      glyph_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item.font_byte = b;
    item.first_of_string = f;
    glyph_valid <= 1'b1;
    glyph_in <= item;
    do @(posedge clk); while (!glyph_ready);
    expand_glyph(item);
  endtask

  // Stop sending and wait until every expected pixel has come
  task automatic drain_pixels();
    glyph_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_random_config();
    write_reg(CFG_FG_COLOR, pick_edge(0, 255));
    write_reg(CFG_BACK_COLOR, pick_edge(0, 255));
    write_reg(CFG_GLYPH_WIDTH, ($urandom_range(0, 3) == 0) ? pick_edge(0, 63)
                                                           : 24'($urandom_range(1, 16)));
    write_reg(CFG_GLYPH_HEIGHT, ($urandom_range(0, 3) == 0) ? pick_edge(0, 63)
                                                            : 24'($urandom_range(1, 8)));
    write_reg(CFG_LINE_STRIDE, pick_edge(0, 8191));
    write_reg(CFG_START_X, pick_edge(0, 4095));
    write_reg(CFG_START_Y, pick_edge(0, 4095));
    write_reg(CFG_FRAME_BASE, pick_edge(0, 24'hFFFFFF));
  endtask

  // Strings of whole glyphs with random bits; some cut short or restarted early
  task automatic run_strings(input int unsigned budget);
    int unsigned sent, per_char, n, k;
    sent = 0;
    while (sent < budget) begin
      per_char = ((clamp_dim(regs.glyph_width) + 7) / 8) * clamp_dim(regs.glyph_height);
      n = per_char * $urandom_range(1, 3);
      if ($urandom_range(0, 7) == 0) n = $urandom_range(1, n);
      for (k = 0; k < n && sent < budget; k++) begin
        send_glyph(8'($urandom),
                   (k == 0 && $urandom_range(0, 9) != 0) || ($urandom_range(0, 39) == 0));
        sent++;
      end
    end
    drain_pixels();
  endtask

  // After reset drawing starts at address zero without a restart
  task automatic test_reset_origin();
    send_glyph(8'h80, 1'b0);
    send_glyph(8'h01, 1'b0);
    send_glyph(8'hA5, 1'b0);
    drain_pixels();
  endtask

  // Swapped color extremes, all-set and all-clear bytes, a pause mid-string
  task automatic test_color_extremes();
    write_reg(CFG_FG_COLOR, 24'h00);
    write_reg(CFG_BACK_COLOR, 24'hFF);
    send_glyph(8'hFF, 1'b1);
    send_glyph(8'h00, 1'b0);
    drain_pixels();
    send_glyph(8'h5A, 1'b0);
    send_glyph(8'hA5, 1'b1);
    drain_pixels();
  endtask

  // Partial bytes, glyph end, address wrap, clamped sizes and a zero stride
  task automatic test_glyph_geometry();
    write_reg(CFG_FG_COLOR, 24'h3C);
    write_reg(CFG_BACK_COLOR, 24'hC3);
    write_reg(CFG_GLYPH_WIDTH, 24'd12);
    write_reg(CFG_GLYPH_HEIGHT, 24'd2);
    write_reg(CFG_LINE_STRIDE, 24'd4096);
    write_reg(CFG_START_X, 24'd4095);
    write_reg(CFG_START_Y, 24'd4095);
    write_reg(CFG_FRAME_BASE, 24'hFFFFFF);
    send_glyph(8'hF0, 1'b1);
    send_glyph(8'h0F, 1'b0);
    send_glyph(8'hC3, 1'b0);
    send_glyph(8'h3C, 1'b0);
    send_glyph(8'h81, 1'b0);
    drain_pixels();
    // width and height of zero act as one; byte counter left mid-row
    write_reg(CFG_GLYPH_WIDTH, 24'd0);
    write_reg(CFG_GLYPH_HEIGHT, 24'd0);
    write_reg(CFG_LINE_STRIDE, 24'd0);
    send_glyph(8'h80, 1'b0);
    send_glyph(8'h7F, 1'b0);
    send_glyph(8'hFF, 1'b1);
    send_glyph(8'h00, 1'b0);
    drain_pixels();
    // oversize dimensions are held to the maximum
    write_reg(CFG_GLYPH_WIDTH, 24'd63);
    write_reg(CFG_GLYPH_HEIGHT, 24'd63);
    write_reg(CFG_LINE_STRIDE, 24'd8191);
    send_glyph(8'h96, 1'b1);
    send_glyph(8'h69, 1'b0);
    send_glyph(8'hE7, 1'b0);
    send_glyph(8'h18, 1'b0);
    send_glyph(8'h55, 1'b0);
    drain_pixels();
  endtask

  // Random register settings, one phase without idling
  task automatic test_random_strings();
    int unsigned phase;
    for (phase = 0; phase < 5; phase++) begin
      write_random_config();
      quiet = (phase == 2);
      run_strings(100);
    end
    quiet = 1'b0;
  endtask

  // Receiver stalls
  always @(posedge clk) begin
    if (rst) begin
      pixel_ready <= 1'b0;
      stall_left <= 0;
    end else if (quiet) begin
      pixel_ready <= 1'b1;
    end else if (stall_left > 0) begin
      pixel_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 3) == 0) begin
      pixel_ready <= 1'b0;
      stall_left <= pick_gap();
    end else begin
      pixel_ready <= 1'b1;
    end
  end

  // Compare each accepted pixel with the oldest expectation
  always @(posedge clk) begin
    if (!rst && pixel_valid && pixel_ready) begin
      if (pending_pixels.size() == 0) begin
        mismatch_count++;
        $display("%0t unexpected pixel: expected none, got %h", $time, pixel_out);
      end else begin
        want_pixel = pending_pixels.pop_front();
        if (pixel_out.pixel_address !== want_pixel.pixel_address) begin
          mismatch_count++;
          $display("%0t pixel_address: expected %h, got %h", $time,
                   want_pixel.pixel_address, pixel_out.pixel_address);
        end
        if (pixel_out.pixel_color !== want_pixel.pixel_color) begin
          mismatch_count++;
          $display("%0t pixel_color: expected %h, got %h", $time,
                   want_pixel.pixel_color, pixel_out.pixel_color);
        end
        if (pixel_out.last !== want_pixel.last) begin
          mismatch_count++;
          $display("%0t last: expected %b, got %b", $time, want_pixel.last, pixel_out.last);
        end
      end
    end
  end

  initial begin
    reset_model();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_origin();
    test_color_extremes();
    test_glyph_geometry();
    test_random_strings();
    drain_pixels();
    if (mismatch_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Run limit
  initial begin
    #20_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

// File: filelist.f
rtl/gce_pkg.sv
rtl/gce_front.sv
rtl/gce_queue.sv
rtl/gce_back.sv
rtl/glyph_color_expansion.sv
tb/sv/glyph_color_expansion_tb.sv
